// ===== src/aup_pkg.sv =====
// aup_pkg: shared types, character codes and the character classifier
// for the ascii unsigned integer parser; depends on nothing
`default_nettype none

package aup_pkg;

    localparam int CHAR_W  = 8;
    localparam int BASE_W  = 6;
    localparam int DIGIT_W = 6;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 16;
    localparam int TDATA_W = VALUE_W + COUNT_W;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [DIGIT_W-1:0] LETTER_OFS = 6'd10;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_START,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    typedef struct packed {
        logic               ws;
        logic               sign;
        logic               minus;
        logic               zero;
        logic               hex_x;
        logic               alnum;
        logic [DIGIT_W-1:0] digit;
    } t_char_class;

    function automatic t_char_class classify(input logic [CHAR_W-1:0] c);
        t_char_class r;
        r.ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
        r.sign  = (c == CH_PLUS) || (c == CH_MINUS);
        r.minus = (c == CH_MINUS);
        r.zero  = (c == CH_0);
        r.hex_x = (c == CH_LX) || (c == CH_UX);
        r.alnum = 1'b1;
        r.digit = '0;
        if (c >= CH_0 && c <= CH_9) begin
            r.digit = DIGIT_W'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            r.digit = DIGIT_W'(c - CH_LA) + LETTER_OFS;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            r.digit = DIGIT_W'(c - CH_UA) + LETTER_OFS;
        end else begin
            r.alnum = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/aup_core.sv =====
// aup_core: per-character parse state, multiply-add accumulator and stop detect
// depends on aup_pkg
`default_nettype none

module aup_core #(
    parameter int VALUE_BITS = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_beat,
    input  wire  [aup_pkg::CHAR_W-1:0]       i_char,
    input  wire  [aup_pkg::BASE_W-1:0]       i_base,
    output logic                             o_res_valid,
    output logic [VALUE_BITS-1:0]            o_res_value,
    output logic [COUNT_BITS-1:0]            o_res_count
);

    aup_pkg::t_phase             r_phase, n_phase;
    logic [VALUE_BITS-1:0]       r_acc, n_acc;
    logic                        r_minus, n_minus;
    logic [aup_pkg::BASE_W-1:0]  r_base, n_base;
    logic [COUNT_BITS-1:0]       r_count, n_count;

    aup_pkg::t_char_class        w_cls;
    logic [aup_pkg::BASE_W-1:0]  w_eff_base;
    logic [aup_pkg::BASE_W-1:0]  w_dig_base;
    logic                        w_in_start;
    logic                        w_skip_ws;
    logic                        w_take_sign;
    logic                        w_take_zero;
    logic                        w_take_x;
    logic                        w_take_dig;
    logic                        w_stop;
    logic [COUNT_BITS-1:0]       w_count_inc;
    logic [VALUE_BITS+aup_pkg::BASE_W-1:0] w_prod;
    logic [VALUE_BITS-1:0]       w_acc_next;

    // character decode and the action it selects
    always_comb begin
        w_cls       = aup_pkg::classify(i_char);
        w_eff_base  = (r_phase == aup_pkg::PH_SPACE) ? i_base : r_base;
        w_skip_ws   = (r_phase == aup_pkg::PH_SPACE) && w_cls.ws;
        w_take_sign = (r_phase == aup_pkg::PH_SPACE) && !w_cls.ws && w_cls.sign;
        w_in_start  = ((r_phase == aup_pkg::PH_SPACE) && !w_cls.ws && !w_cls.sign)
                      || (r_phase == aup_pkg::PH_START);
        w_take_zero = w_in_start && w_cls.zero
                      && (w_eff_base == aup_pkg::BASE_AUTO || w_eff_base == aup_pkg::BASE_HEX);
        w_take_x    = (r_phase == aup_pkg::PH_ZERO) && w_cls.hex_x;
        w_dig_base  = w_eff_base;
        if (w_eff_base == aup_pkg::BASE_AUTO) begin
            if (w_in_start) begin
                w_dig_base = aup_pkg::BASE_DEC;
            end else if (r_phase == aup_pkg::PH_ZERO) begin
                w_dig_base = aup_pkg::BASE_OCT;
            end
        end
        w_take_dig  = !w_skip_ws && !w_take_sign && !w_take_zero && !w_take_x
                      && w_cls.alnum && (w_cls.digit < w_dig_base);
        w_stop      = !w_skip_ws && !w_take_sign && !w_take_zero && !w_take_x && !w_take_dig;
        w_count_inc = (&r_count) ? r_count : r_count + 1'b1;
        w_prod      = {aup_pkg::BASE_W'(0), r_acc} * {VALUE_BITS'(0), w_dig_base};
        w_acc_next  = w_prod[VALUE_BITS-1:0] + VALUE_BITS'(w_cls.digit);
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_minus = r_minus;
        n_base  = r_base;
        n_count = r_count;
        if (i_beat) begin
            priority if (w_skip_ws) begin
                n_count = w_count_inc;
            end else if (w_take_sign) begin
                n_phase = aup_pkg::PH_START;
                n_minus = w_cls.minus;
                n_base  = w_eff_base;
                n_count = w_count_inc;
            end else if (w_take_zero) begin
                n_phase = aup_pkg::PH_ZERO;
                n_base  = w_eff_base;
                n_count = w_count_inc;
            end else if (w_take_x) begin
                n_phase = aup_pkg::PH_DIGITS;
                n_base  = aup_pkg::BASE_HEX;
                n_count = w_count_inc;
            end else if (w_take_dig) begin
                n_phase = aup_pkg::PH_DIGITS;
                n_base  = w_dig_base;
                n_acc   = w_acc_next;
                n_count = w_count_inc;
            end else begin
                n_phase = aup_pkg::PH_SPACE;
                n_acc   = '0;
                n_minus = 1'b0;
                n_base  = aup_pkg::BASE_AUTO;
                n_count = '0;
            end
        end
    end

    // result
    always_comb begin
        o_res_valid = i_beat && w_stop;
        o_res_value = r_minus ? (VALUE_BITS'(0) - r_acc) : r_acc;
        o_res_count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= aup_pkg::PH_SPACE;
            r_acc   <= '0;
            r_minus <= 1'b0;
            r_base  <= aup_pkg::BASE_AUTO;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_minus <= n_minus;
            r_base  <= n_base;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== src/ascii_unsigned_integer_parser.sv =====
// ascii_unsigned_integer_parser: top level with base register and output buffer
// depends on aup_pkg and aup_core
//
// Usage:
//   s_axis carries one ASCII character per beat in tdata. Leading space, tab,
//   LF and CR are skipped, then one optional sign, an optional 0x prefix and
//   digits below the base. The first character that does not fit ends the
//   number; it is dropped and produces one beat on m_axis holding the value
//   (negated if a minus sign was seen) and the count of characters consumed.
//   i_cfg_we/i_cfg_wdata write the base (0 = auto 8/10/16); it is sampled at
//   the first non-blank character of each number.
// Timing:
//   one character per cycle while s_axis_tready is high; the multiply-add of
//   the accumulator by the base is done combinationally for each character.
//   A result is registered into the output buffer when its stop character is taken.
// Reset:
//   synchronous, active low; clears the parse state, sets base to 0 and
//   empties the output buffer.
// Stall:
//   the output holds two results; s_axis_tready drops only while both are
//   full, so the parser keeps taking characters while one result waits.
`default_nettype none

module ascii_unsigned_integer_parser #(
    parameter int VALUE_BITS = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [aup_pkg::BASE_W-1:0]       i_cfg_wdata,   // number_base
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [aup_pkg::CHAR_W-1:0]       s_axis_tdata,  // char_in
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [aup_pkg::TDATA_W-1:0]      m_axis_tdata   // parsed_value, chars_consumed
);

    logic [aup_pkg::BASE_W-1:0]  r_number_base;
    logic                        r_out_valid, n_out_valid;
    logic [aup_pkg::TDATA_W-1:0] r_out_data, n_out_data;
    logic                        r_skd_valid, n_skd_valid;
    logic [aup_pkg::TDATA_W-1:0] r_skd_data, n_skd_data;

    logic                        w_beat;
    logic                        w_res_valid;
    logic [VALUE_BITS-1:0]       w_res_value;
    logic [COUNT_BITS-1:0]       w_res_count;
    logic [aup_pkg::TDATA_W-1:0] w_res_data;
    logic                        w_pop;

    assign s_axis_tready = !r_skd_valid;
    assign w_beat        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    aup_core #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (w_beat),
        .i_char      (s_axis_tdata),
        .i_base      (r_number_base),
        .o_res_valid (w_res_valid),
        .o_res_value (w_res_value),
        .o_res_count (w_res_count)
    );

    assign w_res_data = {aup_pkg::COUNT_W'(w_res_count), aup_pkg::VALUE_W'(w_res_value)};
    assign w_pop      = r_out_valid && m_axis_tready;

    // two-entry output buffer
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_skd_valid = r_skd_valid;
        n_skd_data  = r_skd_data;
        if (w_pop) begin
            if (r_skd_valid) begin
                n_out_data  = r_skd_data;
                n_skd_valid = 1'b0;
            end else begin
                n_out_valid = w_res_valid;
                n_out_data  = w_res_data;
            end
        end else if (!r_out_valid) begin
            n_out_valid = w_res_valid;
            n_out_data  = w_res_data;
        end else if (w_res_valid) begin
            n_skd_valid = 1'b1;
            n_skd_data  = w_res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= aup_pkg::BASE_AUTO;
            r_out_valid   <= 1'b0;
            r_skd_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_number_base <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
            r_skd_valid <= n_skd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_skd_data <= n_skd_data;
    end

endmodule

`default_nettype wire

// ===== src/aup_checker.sv =====
// aup_checker: port-level checks for the ascii unsigned integer parser,
// bound to the top level; depends on aup_pkg
`default_nettype none

module aup_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          s_axis_tvalid,
    input wire                          s_axis_tready,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [aup_pkg::TDATA_W-1:0]   m_axis_tdata
);

    // stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // input back-pressure only with a result pending
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // a new result follows an accepted character
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without accepted character");

    // output empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

    // stalled payload holds
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

endmodule

bind ascii_unsigned_integer_parser aup_checker u_aup_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/tb_ascii_unsigned_integer_parser.sv =====
// tb_ascii_unsigned_integer_parser: self-checking bench for the ascii integer parser,
// with directed and random character streams, random idling on both streams and back-pressure
// depends on aup_pkg and ascii_unsigned_integer_parser
module tb_ascii_unsigned_integer_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 4;
    localparam int PARSE_LATENCY  = 2;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CHARS   = 80;
    localparam logic [6:0] NOT_DIGIT = 7'd127;
    localparam logic [aup_pkg::BASE_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [aup_pkg::BASE_W-1:0] BASE_BIN  = 6'd2;
    localparam logic [aup_pkg::BASE_W-1:0] BASE_MAX  = 6'd36;
    localparam logic [aup_pkg::BASE_W-1:0] BASE_OVER = 6'd37;
    localparam logic [aup_pkg::BASE_W-1:0] BASE_TOP  = 6'd63;
    localparam logic [aup_pkg::CHAR_W-1:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic [aup_pkg::VALUE_W-1:0] value;
        logic [aup_pkg::COUNT_W-1:0] count;
    } t_parse_result;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [aup_pkg::BASE_W-1:0]    i_cfg_wdata   = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [aup_pkg::CHAR_W-1:0]    s_axis_tdata  = '0;   // char_in
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [aup_pkg::TDATA_W-1:0]   m_axis_tdata;         // parsed_value, chars_consumed

    // parser model state
    logic [aup_pkg::BASE_W-1:0]    number_base_q = '0;
    aup_pkg::t_phase               phase_q       = aup_pkg::PH_SPACE;
    logic [aup_pkg::VALUE_W-1:0]   acc_q         = '0;
    logic                          minus_q       = 1'b0;
    logic [aup_pkg::BASE_W-1:0]    radix_q       = '0;
    logic [aup_pkg::COUNT_W-1:0]   count_q       = '0;

    t_parse_result        expected_numbers[$];
    int                   mismatch_count = 0;
    int                   chars_sent     = 0;
    int                   quiet_cycles   = 0;
    int                   src_gap_max    = 0;
    int                   sink_gap_max   = 0;
    logic                 sink_long_hold = 1'b0;

    logic [aup_pkg::CHAR_W-1:0] blanks[4] = '{aup_pkg::CH_SPACE, aup_pkg::CH_TAB,
                                               aup_pkg::CH_LF, aup_pkg::CH_CR};

    ascii_unsigned_integer_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic void bump_count();
        if (count_q != '1) begin
            count_q++;
        end
    endfunction

    function automatic void parse_char(input logic [aup_pkg::CHAR_W-1:0] c);
        aup_pkg::t_phase ph;
        logic [6:0] d;
        t_parse_result r;
        ph = phase_q;
        if (ph == aup_pkg::PH_SPACE) begin
            if (c == aup_pkg::CH_SPACE || c == aup_pkg::CH_TAB
                || c == aup_pkg::CH_LF || c == aup_pkg::CH_CR) begin
                bump_count();
                return;
            end
            radix_q = number_base_q;
            if (c == aup_pkg::CH_MINUS || c == aup_pkg::CH_PLUS) begin
                if (c == aup_pkg::CH_MINUS) begin
                    minus_q = 1'b1;
                end
                bump_count();
                phase_q = aup_pkg::PH_START;
                return;
            end
            ph = aup_pkg::PH_START;
        end
        if (ph == aup_pkg::PH_START) begin
            if (c == aup_pkg::CH_0
                && (radix_q == aup_pkg::BASE_AUTO || radix_q == aup_pkg::BASE_HEX)) begin
                bump_count();
                phase_q = aup_pkg::PH_ZERO;
                return;
            end
            if (radix_q == aup_pkg::BASE_AUTO) begin
                radix_q = aup_pkg::BASE_DEC;
            end
        end else if (ph == aup_pkg::PH_ZERO) begin
            if (c == aup_pkg::CH_LX || c == aup_pkg::CH_UX) begin
                bump_count();
                radix_q = aup_pkg::BASE_HEX;
                phase_q = aup_pkg::PH_DIGITS;
                return;
            end
            if (radix_q == aup_pkg::BASE_AUTO) begin
                radix_q = aup_pkg::BASE_OCT;
            end
        end
        if (c >= aup_pkg::CH_0 && c <= aup_pkg::CH_9) begin
            d = 7'(c - aup_pkg::CH_0);
        end else if (c >= aup_pkg::CH_LA && c <= aup_pkg::CH_LZ) begin
            d = 7'(c - aup_pkg::CH_LA) + 7'd10;
        end else if (c >= aup_pkg::CH_UA && c <= aup_pkg::CH_UZ) begin
            d = 7'(c - aup_pkg::CH_UA) + 7'd10;
        end else begin
            d = NOT_DIGIT;
        end
        if (d < 7'(radix_q)) begin
            acc_q = acc_q * aup_pkg::VALUE_W'(radix_q) + aup_pkg::VALUE_W'(d);
            bump_count();
            phase_q = aup_pkg::PH_DIGITS;
            return;
        end
        r.value = minus_q ? (aup_pkg::VALUE_W'(0) - acc_q) : acc_q;
        r.count = count_q;
        expected_numbers.push_back(r);
        phase_q = aup_pkg::PH_SPACE;
        acc_q   = '0;
        minus_q = 1'b0;
        radix_q = '0;
        count_q = '0;
    endfunction

    task automatic send_char(input logic [aup_pkg::CHAR_W-1:0] c);
        int gap;
        gap = $urandom_range(src_gap_max, 0);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= c;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        parse_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_numbers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_base(input logic [aup_pkg::BASE_W-1:0] b);
        wait_drained();
        repeat (PARSE_LATENCY) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= b;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        number_base_q = b;
    endtask

    task automatic pick_gaps();
        case ($urandom_range(3, 0))
            0: src_gap_max = 0;
            1: src_gap_max = 12;
            default: src_gap_max = $urandom_range(12, 0);
        endcase
        case ($urandom_range(3, 0))
            0: sink_gap_max = 0;
            1: sink_gap_max = 12;
            default: sink_gap_max = $urandom_range(12, 0);
        endcase
    endtask

    // blanks, sign, prefix, digits valid for the current base, then an end character (random, so not always a stop)
    task automatic send_random_number();
        int lim;
        int n_dig;
        int d;
        repeat ($urandom_range(3, 0)) send_char(blanks[$urandom_range(3, 0)]);
        case ($urandom_range(3, 0))
            0: send_char(aup_pkg::CH_MINUS);
            1: send_char(aup_pkg::CH_PLUS);
            default: ;
        endcase
        lim = int'(number_base_q);
        if (number_base_q == aup_pkg::BASE_AUTO) begin
            case ($urandom_range(2, 0))
                0: begin
                    send_char(aup_pkg::CH_0);
                    send_char($urandom_range(1, 0) ? aup_pkg::CH_LX : aup_pkg::CH_UX);
                    lim = 16;
                end
                1: begin
                    send_char(aup_pkg::CH_0);
                    lim = 8;
                end
                default: lim = 10;
            endcase
        end else if (number_base_q == aup_pkg::BASE_HEX && $urandom_range(1, 0)) begin
            send_char(aup_pkg::CH_0);
            send_char($urandom_range(1, 0) ? aup_pkg::CH_LX : aup_pkg::CH_UX);
        end
        if (lim > 36) begin
            lim = 36;
        end
        n_dig = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 14) : $urandom_range(6, 0);
        repeat (n_dig) begin
            d = $urandom_range(lim - 1, 0);
            if (d < 10) begin
                send_char(aup_pkg::CH_0 + aup_pkg::CHAR_W'(d));
            end else begin
                send_char(($urandom_range(1, 0) ? aup_pkg::CH_LA : aup_pkg::CH_UA)
                          + aup_pkg::CHAR_W'(d - 10));
            end
        end
        case ($urandom_range(3, 0))
            0: send_char(CH_NUL);
            1: send_char(aup_pkg::CH_SPACE);
            2: send_char(8'h2C);
            default: send_char(aup_pkg::CHAR_W'($urandom_range(255, 0)));
        endcase
    endtask

    task automatic run_random_chars(input int n_chars);
        int start;
        start = chars_sent;
        while (chars_sent - start < n_chars) begin
            if ($urandom_range(9, 0) == 0) begin
                send_char(aup_pkg::CHAR_W'($urandom_range(255, 0)));
            end else begin
                send_random_number();
            end
        end
        send_char(CH_NUL);
    endtask

    // base left at its reset value: blanks, signs, auto prefixes, bare sign, empty string
    task automatic test_auto_base_directed();
        src_gap_max  = 3;
        sink_gap_max = 3;
        send_char(aup_pkg::CH_SPACE);
        send_char(aup_pkg::CH_TAB);
        send_char(aup_pkg::CH_LF);
        send_char(aup_pkg::CH_CR);
        send_text("-0x1fZ");
        send_text("+0179");
        send_text("0xg");
        send_text("-");
        send_char(CH_NUL);
        send_char(CH_NUL);
        send_text("42");
        send_char(8'hFF);
        wait_drained();
    endtask

    task automatic test_fixed_base_directed();
        write_base(BASE_ONE);
        send_text("001+1");
        write_base(aup_pkg::BASE_HEX);
        send_text("0X Ff/");
        write_base(BASE_MAX);
        send_text("zZ9.0x");
        send_char(CH_NUL);
        write_base(BASE_TOP);
        send_text("-Zz9@");
        wait_drained();
    endtask

    task automatic test_random_bases();
        logic [aup_pkg::BASE_W-1:0] bases[10];
        bases = '{aup_pkg::BASE_AUTO, BASE_ONE, BASE_BIN, aup_pkg::BASE_OCT,
                  aup_pkg::BASE_DEC, aup_pkg::BASE_HEX, BASE_MAX, BASE_OVER, BASE_TOP,
                  aup_pkg::BASE_W'($urandom_range(63, 0))};
        foreach (bases[i]) begin
            write_base(bases[i]);
            pick_gaps();
            run_random_chars(RANDOM_CHARS);
        end
        wait_drained();
    endtask

    // sink stops for a long stretch while short numbers keep coming
    task automatic test_output_backpressure();
        write_base(aup_pkg::BASE_DEC);
        src_gap_max    = 0;
        sink_gap_max   = 0;
        sink_long_hold = 1'b1;
        repeat (40) begin
            send_char(aup_pkg::CH_0 + aup_pkg::CHAR_W'($urandom_range(9, 0)));
            send_char(aup_pkg::CH_SPACE);
        end
        wait_drained();
    endtask

    // source stops mid-stream until every result is out, then carries on
    task automatic test_source_pause();
        write_base(aup_pkg::BASE_AUTO);
        pick_gaps();
        run_random_chars(RANDOM_CHARS / 2);
        wait_drained();
        pick_gaps();
        run_random_chars(RANDOM_CHARS / 2);
        wait_drained();
    endtask

    initial begin : result_sink
        int hold;
        forever begin
            @(negedge i_clk);
            if (sink_long_hold) begin
                sink_long_hold = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = $urandom_range(sink_gap_max, 0);
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_numbers.size() == 0) begin
                $error("unexpected result beat, tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                if (m_axis_tdata[aup_pkg::VALUE_W-1:0] !== expected_numbers[0].value) begin
                    $error("parsed_value: expected %h, actual %h",
                           expected_numbers[0].value, m_axis_tdata[aup_pkg::VALUE_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[aup_pkg::TDATA_W-1:aup_pkg::VALUE_W]
                    !== expected_numbers[0].count) begin
                    $error("chars_consumed: expected %0d, actual %0d",
                           expected_numbers[0].count,
                           m_axis_tdata[aup_pkg::TDATA_W-1:aup_pkg::VALUE_W]);
                    mismatch_count++;
                end
                void'(expected_numbers.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_ascii_unsigned_integer_parser failed");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_auto_base_directed();
        test_fixed_base_directed();
        test_random_bases();
        test_output_backpressure();
        test_source_pause();
        wait_drained();
        repeat (PARSE_LATENCY * 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_ascii_unsigned_integer_parser passed");
        end else begin
            $display("tb_ascii_unsigned_integer_parser failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/aup_pkg.sv
src/aup_core.sv
src/ascii_unsigned_integer_parser.sv
src/aup_checker.sv
bench/tb_ascii_unsigned_integer_parser.sv
